// ----- rtl/dnf_pkg.sv -----
`timescale 1ns / 1ps

package dnf_pkg;

    localparam int NONCE_DEPTH = 32;
    localparam int STAT_DEPTH  = 64;

    localparam int NONCE_W  = 32;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 16;
    localparam int SHARE_W  = 7;

    localparam int COUNT_MAX = 127;

    localparam int NONCE_AW  = $clog2(NONCE_DEPTH);
    localparam int STAT_AW   = $clog2(STAT_DEPTH);
    localparam int CLR_DEPTH = (NONCE_DEPTH > STAT_DEPTH) ? NONCE_DEPTH : STAT_DEPTH;
    localparam int SCAN_W    = $clog2(CLR_DEPTH) + 1;
    localparam int COUNT_W   = $clog2(STAT_DEPTH + 1);
    localparam int EXT_W     = (COUNT_W > SHARE_W) ? COUNT_W : SHARE_W;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_COUNT  = 1'b1;

    typedef struct packed {
        logic                op;
        logic [NONCE_W-1:0]  nonce;
        logic [TIME_W-1:0]   time_sec;
        logic [WINDOW_W-1:0] window_sec;
    } item_t;

    typedef struct packed {
        logic               idle;
        logic               done;
        logic               accepted;
        logic [SHARE_W-1:0] share_count;
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

endpackage

// ----- rtl/dnf_in_if.sv -----
`timescale 1ns / 1ps

interface dnf_in_if import dnf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op;
    logic [NONCE_W-1:0]  nonce;
    logic [TIME_W-1:0]   time_sec;
    logic [WINDOW_W-1:0] window_sec;

    modport source (output valid, op, nonce, time_sec, window_sec, input ready);
    modport sink   (input valid, op, nonce, time_sec, window_sec, output ready);
endinterface

// ----- rtl/dnf_out_if.sv -----
`timescale 1ns / 1ps

interface dnf_out_if import dnf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [SHARE_W-1:0] share_count;

    modport source (output valid, accepted, share_count, input ready);
    modport sink   (input valid, accepted, share_count, output ready);
endinterface

// ----- rtl/dnf_ram.sv -----
`timescale 1ns / 1ps

module dnf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/dnf_ctrl.sv -----
`timescale 1ns / 1ps

module dnf_ctrl import dnf_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    input  logic    take,
    output status_t status
);

    state_t              state_reg, state_next;
    logic [SCAN_W-1:0]   idx_reg, idx_next;
    logic                pend_reg, pend_next;
    item_t               item_reg, item_next;
    logic                hit_reg, hit_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [NONCE_AW-1:0] nonce_ptr_reg, nonce_ptr_next;
    logic [STAT_AW-1:0]  time_ptr_reg, time_ptr_next;
    logic                acc_reg, acc_next;
    logic [SHARE_W-1:0]  share_reg, share_next;

    logic                n_we, t_we;
    logic [NONCE_AW-1:0] n_waddr;
    logic [STAT_AW-1:0]  t_waddr;
    logic [NONCE_W-1:0]  n_wdata, n_rdata;
    logic [TIME_W-1:0]   t_wdata, t_rdata;

    logic [SCAN_W-1:0]   scan_len;
    logic [TIME_W-1:0]   age;
    logic                hit_cur;
    logic [COUNT_W-1:0]  cnt_cur;
    logic [EXT_W-1:0]    cnt_ext;

    dnf_ram #(.WIDTH(NONCE_W), .DEPTH(NONCE_DEPTH)) u_nonce_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (idx_reg[NONCE_AW-1:0]),
        .rdata (n_rdata)
    );

    dnf_ram #(.WIDTH(TIME_W), .DEPTH(STAT_DEPTH)) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (idx_reg[STAT_AW-1:0]),
        .rdata (t_rdata)
    );

    // compare / count on the data returned for the previous address
    assign scan_len = (item_reg.op == OP_COUNT) ? SCAN_W'(STAT_DEPTH) : SCAN_W'(NONCE_DEPTH);
    assign age      = item_reg.time_sec - t_rdata;
    assign hit_cur  = hit_reg | (pend_reg && (n_rdata == item_reg.nonce));
    assign cnt_cur  = cnt_reg + COUNT_W'(pend_reg && (age < TIME_W'(item_reg.window_sec)));
    assign cnt_ext  = EXT_W'(cnt_cur);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        item_next      = item_reg;
        hit_next       = hit_reg;
        cnt_next       = cnt_reg;
        nonce_ptr_next = nonce_ptr_reg;
        time_ptr_next  = time_ptr_reg;
        acc_next       = acc_reg;
        share_next     = share_reg;
        n_we           = 1'b0;
        t_we           = 1'b0;
        n_waddr        = nonce_ptr_reg;
        t_waddr        = time_ptr_reg;
        n_wdata        = item_reg.nonce;
        t_wdata        = item_reg.time_sec;

        case (state_reg)
            S_CLEAR:
            begin
                n_we    = (idx_reg < SCAN_W'(NONCE_DEPTH));
                t_we    = (idx_reg < SCAN_W'(STAT_DEPTH));
                n_waddr = idx_reg[NONCE_AW-1:0];
                t_waddr = idx_reg[STAT_AW-1:0];
                n_wdata = '0;
                t_wdata = '0;
                if (idx_reg == SCAN_W'(CLR_DEPTH - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SCAN_W'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                hit_next = hit_cur;
                cnt_next = cnt_cur;
                if (idx_reg != scan_len)
                begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + SCAN_W'(1);
                end
                else if (pend_reg)
                begin
                    // last entry compared: commit and post the result
                    state_next = S_DONE;
                    if (item_reg.op == OP_COUNT)
                    begin
                        acc_next   = 1'b0;
                        share_next = (cnt_ext > EXT_W'(COUNT_MAX)) ?
                                     SHARE_W'(COUNT_MAX) : cnt_ext[SHARE_W-1:0];
                    end
                    else
                    begin
                        acc_next   = !hit_cur;
                        share_next = '0;
                        if (!hit_cur)
                        begin
                            n_we = 1'b1;
                            t_we = 1'b1;
                            nonce_ptr_next = (nonce_ptr_reg == NONCE_AW'(NONCE_DEPTH - 1)) ?
                                             '0 : nonce_ptr_reg + NONCE_AW'(1);
                            time_ptr_next  = (time_ptr_reg == STAT_AW'(STAT_DEPTH - 1)) ?
                                             '0 : time_ptr_reg + STAT_AW'(1);
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            nonce_ptr_reg <= '0;
            time_ptr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            nonce_ptr_reg <= nonce_ptr_next;
            time_ptr_reg  <= time_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        hit_reg   <= hit_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        share_reg <= share_next;
    end

    assign status.idle        = (state_reg == S_IDLE);
    assign status.done        = (state_reg == S_DONE);
    assign status.accepted    = acc_reg;
    assign status.share_count = share_reg;

endmodule

// ----- rtl/duplicate_nonce_filter_rate_window_core.sv -----
`timescale 1ns / 1ps

// duplicate nonce filter with share-rate window. a submit item (op 0) is checked
// against the 32 most recently accepted nonces; a new nonce is stored in the nonce
// ring and its time_sec in the 64-entry timestamp ring, and the result says
// accepted. a count item (op 1) returns how many stored timestamps are younger
// than window_sec (age taken mod 2^32). every item gives exactly one result.
// both rings live in single-port-read rams and are walked one entry per cycle;
// a submit item walks the NONCE_DEPTH nonce ring, a count item the STAT_DEPTH
// timestamp ring, and the next item can be taken once the result has moved into
// the output slot; one item is in work at a time. after reset a clearing pass
// over max(NONCE_DEPTH, STAT_DEPTH) = 64 addresses zeroes both rams while
// req.ready stays low, so a zero nonce counts as a duplicate until overwritten.
module duplicate_nonce_filter_rate_window_core import dnf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    dnf_in_if.sink           req,
    dnf_out_if.source        rsp
);

    status_t            st;
    item_t              item;
    logic               start;
    logic               take;

    // output slot: lets the core finish while a result is still waiting
    logic               out_valid_reg;
    logic               out_acc_reg;
    logic [SHARE_W-1:0] out_share_reg;

    assign item.op         = req.op;
    assign item.nonce      = req.nonce;
    assign item.time_sec   = req.time_sec;
    assign item.window_sec = req.window_sec;

    // items enter only when the scan engine is idle (not clearing, not busy)
    assign req.ready = st.idle;
    assign start     = req.valid && req.ready;

    // move a finished result into the output slot when it is free or draining
    assign take = st.done && (!out_valid_reg || rsp.ready);

    dnf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .take   (take),
        .status (st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_acc_reg   <= st.accepted;
            out_share_reg <= st.share_count;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.accepted    = out_acc_reg;
    assign rsp.share_count = out_share_reg;

    // an accepted item always puts the engine to work
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !st.idle)
        else $error("engine still idle after item accept");

    // handing a result to the output slot returns the engine to idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> st.idle)
        else $error("engine not idle after result handoff");

    // a result never carries both an accept flag and a share count
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.accepted && (rsp.share_count != '0)))
        else $error("result mixes submit and count fields");

endmodule
